// ===== src/mtlp_pkg.sv =====
// shared constants, a type and a helper function of the teleinfo line parser
package mtlp_pkg;

  // bytes held in one line before the next byte restarts it
  localparam logic [7:0] LINE_LIMIT = 8'd128;

  localparam logic [6:0] CH_STX   = 7'h02;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CSUM_BIAS = 7'h20;

  localparam logic [7:0] ERROR_LIMIT_RESET = 8'd10;
  localparam logic [7:0] ERROR_COUNT_MAX   = 8'd255;

  localparam logic [2:0] LBL_HCHP  = 3'd0;
  localparam logic [2:0] LBL_HCHC  = 3'd1;
  localparam logic [2:0] LBL_IINST = 3'd2;
  localparam logic [2:0] LBL_PAPP  = 3'd3;
  localparam logic [2:0] LBL_PTEC  = 3'd4;
  localparam logic [2:0] LBL_OTHER = 3'd5;

  localparam logic [31:0] PAT_HCHP  = 32'h48434850;
  localparam logic [31:0] PAT_HCHC  = 32'h48434843;
  localparam logic [39:0] PAT_IINST = 40'h49494E5354;
  localparam logic [31:0] PAT_PAPP  = 32'h50415050;
  localparam logic [39:0] PAT_PTEC  = 40'h5054454320;

  localparam logic [4:0] SEEN_ALL = 5'h1F;

  localparam logic [1:0] PH_LABEL  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  typedef struct packed {
    logic [2:0] label_code;
    logic       ok;
  } line_eval_t;

  // acc * 10 + digit, saturating at all ones
  function automatic logic [31:0] dec_step(input logic [31:0] acc, input logic [3:0] digit);
    logic [35:0] t;
    t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};
    dec_step = (t[35:32] != 4'd0) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

endpackage

// ===== src/mtlp_rx_if.sv =====
// received byte channel
interface mtlp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/mtlp_res_if.sv =====
// parsed line result channel
interface mtlp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  label_code;
  logic [31:0] field_value;
  logic        checksum_ok;
  logic        set_complete;
  logic        error_abort;
  modport source (output valid, output label_code, output field_value, output checksum_ok,
                  output set_complete, output error_abort, input ready);
  modport sink (input valid, input label_code, input field_value, input checksum_ok,
                input set_complete, input error_abort, output ready);
endinterface

// ===== src/mtlp_cfg_if.sv =====
// error limit write channel
interface mtlp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] error_limit;
  modport source (output valid, output error_limit, input ready);
  modport sink (input valid, input error_limit, output ready);
endinterface

// ===== src/mtlp_line_eval.sv =====
// line checksum check and label decode at end of line
module mtlp_line_eval (
  input  logic [7:0]          running_sum,
  input  logic [6:0]          previous_byte,
  input  logic [6:0]          byte_before_previous,
  input  logic [7:0]          line_position,
  input  logic [39:0]         label_prefix,
  output mtlp_pkg::line_eval_t eval
);
  import mtlp_pkg::*;

  logic [7:0] sum_body;
  logic       ok;
  logic [2:0] code;

  // last separator and check character are not part of the sum
  assign sum_body = running_sum - {1'b0, previous_byte} - {1'b0, byte_before_previous};
  assign ok = (line_position >= 8'd3) &&
              (({1'b0, sum_body[5:0]} + CSUM_BIAS) == previous_byte);

  always_comb begin
    code = LBL_OTHER;
    if (ok) begin
      if (label_prefix[39:8] == PAT_HCHP) code = LBL_HCHP;
      else if (label_prefix[39:8] == PAT_HCHC) code = LBL_HCHC;
      else if (label_prefix == PAT_IINST) code = LBL_IINST;
      else if (label_prefix[39:8] == PAT_PAPP) code = LBL_PAPP;
      else if (label_prefix == PAT_PTEC) code = LBL_PTEC;
    end
  end

  assign eval.label_code = code;
  assign eval.ok         = ok;

endmodule

// ===== src/meter_teleinfo_line_parser_core.sv =====
// teleinfo historic line parser: byte in, one result per end of line
//
//  channel | dir | payload      | transaction
//  rx      | in  | rx_byte      | one meter byte
//  res     | out | label_code.. | one parsed line, at each CR
//  cfg     | in  | error_limit  | one limit write
//
// one byte per cycle sustained; a byte goes from the input register through
// the line update logic to the result register.
// the only stall is a CR while the result register is full and not taken.
// rst is synchronous: line state, label set, error count clear, limit 10.
module meter_teleinfo_line_parser_core (
  input logic          clk,
  input logic          rst,
  mtlp_rx_if.sink      rx,
  mtlp_res_if.source   res,
  mtlp_cfg_if.sink     cfg
);
  import mtlp_pkg::*;

  logic        in_valid;
  logic [6:0]  in_byte;

  logic [7:0]  error_limit;
  logic [7:0]  running_sum, running_sum_next;
  logic [6:0]  previous_byte, previous_byte_next;
  logic [6:0]  byte_before_previous, byte_before_previous_next;
  logic [7:0]  line_position, line_position_next;
  logic [39:0] label_prefix, label_prefix_next;
  logic [31:0] value_accumulator, value_accumulator_next;
  logic [1:0]  value_phase, value_phase_next;
  logic [31:0] tariff_chars, tariff_chars_next;
  logic [4:0]  seen_labels, seen_labels_next;
  logic [7:0]  error_count, error_count_next;

  logic        out_valid;
  logic [2:0]  out_code, out_code_next;
  logic [31:0] out_value, out_value_next;
  logic        out_ok, out_done, out_abort;
  logic        out_done_next, out_abort_next;

  logic        restart, is_cr, proc_go, res_load;
  logic [7:0]  pos;
  logic [7:0]  err_inc;
  logic [4:0]  seen_set;
  line_eval_t  eval;

  mtlp_line_eval u_eval (
    .running_sum          (running_sum),
    .previous_byte        (previous_byte),
    .byte_before_previous (byte_before_previous),
    .line_position        (line_position),
    .label_prefix         (label_prefix),
    .eval                 (eval)
  );

  assign restart  = (in_byte == CH_STX) || (in_byte == CH_LF) || (line_position >= LINE_LIMIT);
  assign is_cr    = (in_byte == CH_CR);
  assign proc_go  = in_valid && (restart || !is_cr || !out_valid || res.ready);
  assign res_load = proc_go && !restart && is_cr;
  assign rx.ready = !in_valid || proc_go;
  assign cfg.ready = 1'b1;

  // parsing runs two bytes behind the input
  assign pos      = line_position - 8'd2;
  assign err_inc  = (error_count < ERROR_COUNT_MAX) ? error_count + 8'd1 : error_count;
  assign seen_set = (eval.label_code < LBL_OTHER) ?
                    (seen_labels | (5'd1 << eval.label_code)) : seen_labels;

  always_comb begin
    running_sum_next          = running_sum;
    previous_byte_next        = previous_byte;
    byte_before_previous_next = byte_before_previous;
    line_position_next        = line_position;
    label_prefix_next         = label_prefix;
    value_accumulator_next    = value_accumulator;
    value_phase_next          = value_phase;
    tariff_chars_next         = tariff_chars;
    seen_labels_next          = seen_labels;
    error_count_next          = error_count;
    out_code_next             = out_code;
    out_value_next            = out_value;
    out_done_next             = out_done;
    out_abort_next            = out_abort;

    if (proc_go && !restart && !is_cr) begin
      if (line_position >= 8'd2) begin
        for (int i = 0; i < 5; i++) begin
          if (pos == 8'(i))
            label_prefix_next[8*(4-i) +: 8] = label_prefix[8*(4-i) +: 8] |
                                              {1'b0, byte_before_previous};
        end
        for (int i = 5; i < 9; i++) begin
          if (pos == 8'(i))
            tariff_chars_next[8*(8-i) +: 8] = tariff_chars[8*(8-i) +: 8] |
                                              {1'b0, byte_before_previous};
        end
        if (value_phase == PH_LABEL) begin
          if (byte_before_previous == CH_SPACE) value_phase_next = PH_DIGITS;
        end else if (value_phase == PH_DIGITS) begin
          if (byte_before_previous >= CH_ZERO && byte_before_previous <= CH_NINE)
            value_accumulator_next = dec_step(value_accumulator,
                                              byte_before_previous[3:0]);
          else
            value_phase_next = PH_DONE;
        end
      end
      byte_before_previous_next = previous_byte;
      previous_byte_next        = in_byte;
      running_sum_next          = running_sum + {1'b0, in_byte};
      line_position_next        = line_position + 8'd1;
    end

    if (res_load) begin
      out_code_next  = eval.label_code;
      out_value_next = 32'd0;
      out_done_next  = 1'b0;
      out_abort_next = 1'b0;
      if (eval.ok) begin
        if (eval.label_code < LBL_PTEC) out_value_next = value_accumulator;
        else if (eval.label_code == LBL_PTEC) out_value_next = tariff_chars;
        seen_labels_next = seen_set;
        if (seen_set == SEEN_ALL) begin
          out_done_next    = 1'b1;
          seen_labels_next = 5'd0;
          error_count_next = 8'd0;
        end
      end else begin
        error_count_next = err_inc;
        if (err_inc > error_limit) begin
          out_abort_next   = 1'b1;
          seen_labels_next = 5'd0;
          error_count_next = 8'd0;
        end
      end
    end

    // every consumed line-ending byte, and any byte past the line limit, starts a fresh line
    if (proc_go && (restart || is_cr)) begin
      running_sum_next          = 8'd0;
      previous_byte_next        = 7'd0;
      byte_before_previous_next = 7'd0;
      line_position_next        = 8'd0;
      label_prefix_next         = 40'd0;
      value_accumulator_next    = 32'd0;
      value_phase_next          = PH_LABEL;
      tariff_chars_next         = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid             <= 1'b0;
      out_valid            <= 1'b0;
      error_limit          <= ERROR_LIMIT_RESET;
      running_sum          <= 8'd0;
      previous_byte        <= 7'd0;
      byte_before_previous <= 7'd0;
      line_position        <= 8'd0;
      label_prefix         <= 40'd0;
      value_accumulator    <= 32'd0;
      value_phase          <= PH_LABEL;
      tariff_chars         <= 32'd0;
      seen_labels          <= 5'd0;
      error_count          <= 8'd0;
    end else begin
      if (rx.ready) in_valid <= rx.valid;
      out_valid            <= res_load || (out_valid && !res.ready);
      if (cfg.valid) error_limit <= cfg.error_limit;
      running_sum          <= running_sum_next;
      previous_byte        <= previous_byte_next;
      byte_before_previous <= byte_before_previous_next;
      line_position        <= line_position_next;
      label_prefix         <= label_prefix_next;
      value_accumulator    <= value_accumulator_next;
      value_phase          <= value_phase_next;
      tariff_chars         <= tariff_chars_next;
      seen_labels          <= seen_labels_next;
      error_count          <= error_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) in_byte <= rx.rx_byte[6:0];
    if (res_load) out_ok <= eval.ok;
    out_code  <= out_code_next;
    out_value <= out_value_next;
    out_done  <= out_done_next;
    out_abort <= out_abort_next;
  end

  assign res.valid        = out_valid;
  assign res.label_code   = out_code;
  assign res.field_value  = out_value;
  assign res.checksum_ok  = out_ok;
  assign res.set_complete = out_done;
  assign res.error_abort  = out_abort;

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_done && out_abort))
    else $error("set complete and abort on the same line");

  a_bad_line_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_code == LBL_OTHER && out_value == 32'd0 && !out_done))
    else $error("bad line carries a label or value");

  a_session_clear: assert property (@(posedge clk) disable iff (rst)
    (res_load && (out_done_next || out_abort_next)) |=>
      (seen_labels == 5'd0 && error_count == 8'd0))
    else $error("session not cleared after set complete or abort");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    line_position <= LINE_LIMIT)
    else $error("line position beyond limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || res.ready))
    else $error("result register overwritten while held");
`endif

endmodule

// ===== dv/meter_teleinfo_line_parser_core_tb.sv =====
// self-checking testbench for the teleinfo line parser: meter lines in, results checked
`timescale 1ns / 100ps

module meter_teleinfo_line_parser_core_tb;
  import mtlp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef logic [6:0] line_bytes_t[$];

  typedef struct {
    logic [2:0]  code;
    logic [31:0] value;
    logic        ok;
    logic        done;
    logic        abort;
  } line_result_t;

  logic clk = 1'b0;
  logic rst;

  mtlp_rx_if  rx ();
  mtlp_res_if res ();
  mtlp_cfg_if cfg ();

  meter_teleinfo_line_parser_core dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res),
    .cfg(cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0]   meter_bytes[$];
  line_result_t expected_lines[$];
  int           pushed_bytes = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           tx_gap = 0;
  int           res_gap = 0;
  bit           last_stretch = 1'b0;
  logic         rx_took = 1'b0;

  string known_labels[5] = '{"HCHP", "HCHC", "IINST", "PAPP", "PTEC"};
  string other_labels[15] = '{"ADCO", "OPTARIF", "ISOUSC", "IMAX", "HHPHC", "MOTDETAT", "HCH",
                              "IINS", "PTE", "PAP", "IINST1", "IMAX2", "PTECX", "HCHPZ", ""};
  string tariff_names[6] = '{"TH..", "HC..", "HP..", "HN..", "PM..", "HCJB"};

  // line parser model state
  logic [7:0]  limit_now;
  logic [7:0]  line_sum;
  logic [6:0]  last_char;
  logic [6:0] older_char;
  logic [7:0]  line_pos;
  logic [39:0] label_head;
  logic [31:0] value_acc;
  logic [1:0]  value_phase;
  logic [31:0] tariff_word;
  logic [4:0]  seen_mask;
  logic [7:0]  bad_lines;

  function void clear_line();
    line_sum    = '0;
    last_char   = '0;
    older_char  = '0;
    line_pos    = '0;
    label_head  = '0;
    value_acc   = '0;
    value_phase = PH_LABEL;
    tariff_word = '0;
  endfunction

  function void take_line_char(input logic [6:0] c, input logic [7:0] pos);
    logic [63:0] wide;
    if (pos < 5) label_head[8 * (4 - pos) +: 8] = {1'b0, c};
    if (pos >= 5 && pos <= 8) tariff_word[8 * (8 - pos) +: 8] = {1'b0, c};
    case (value_phase)
      PH_LABEL: begin
        if (c == CH_SPACE) value_phase = PH_DIGITS;
      end
      PH_DIGITS: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          wide = {32'd0, value_acc} * 64'd10 + {60'd0, c[3:0]};
          value_acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end else begin
          value_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function void predict_line_byte(input logic [7:0] raw);
    logic [6:0]   b;
    logic [7:0]   s;
    logic [31:0]  top4;
    line_result_t r;
    b = raw[6:0];
    if (b == CH_STX || b == CH_LF || line_pos >= LINE_LIMIT) begin
      clear_line();
      return;
    end
    if (b != CH_CR) begin
      // parsing trails the input by two bytes so separator and check char stay out
      if (line_pos >= 2) take_line_char(older_char, line_pos - 8'd2);
      older_char = last_char;
      last_char  = b;
      line_sum   = line_sum + {1'b0, b};
      line_pos   = line_pos + 8'd1;
      return;
    end
    r.code  = LBL_OTHER;
    r.value = '0;
    r.ok    = 1'b0;
    r.done  = 1'b0;
    r.abort = 1'b0;
    if (line_pos >= 3) begin
      s = line_sum - {1'b0, last_char} - {1'b0, older_char};
      r.ok = (({1'b0, s[5:0]} + CSUM_BIAS) == last_char);
    end
    if (r.ok) begin
      top4 = label_head[39:8];
      if (top4 == PAT_HCHP) r.code = LBL_HCHP;
      else if (top4 == PAT_HCHC) r.code = LBL_HCHC;
      else if (label_head == PAT_IINST) r.code = LBL_IINST;
      else if (top4 == PAT_PAPP) r.code = LBL_PAPP;
      else if (label_head == PAT_PTEC) r.code = LBL_PTEC;
      if (r.code < LBL_PTEC) r.value = value_acc;
      else if (r.code == LBL_PTEC) r.value = tariff_word;
      if (r.code != LBL_OTHER) seen_mask[r.code] = 1'b1;
      if (seen_mask == SEEN_ALL) begin
        r.done    = 1'b1;
        seen_mask = '0;
        bad_lines = '0;
      end
    end else begin
      if (bad_lines != ERROR_COUNT_MAX) bad_lines = bad_lines + 8'd1;
      if (bad_lines > limit_now) begin
        r.abort   = 1'b1;
        seen_mask = '0;
        bad_lines = '0;
      end
    end
    clear_line();
    expected_lines.push_back(r);
  endfunction

  function void check_field(input string fname, input logic [31:0] want_v, input logic [31:0] got);
    if (got !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got);
      mismatch_count++;
    end
  endfunction

  // stimulus helpers
  function void push_raw(input logic [7:0] b);
    meter_bytes.push_back(b);
    pushed_bytes++;
  endfunction

  function void push_byte(input logic [6:0] c);
    push_raw({1'($urandom_range(0, 3) == 0), c});
  endfunction

  function automatic line_bytes_t str_bytes(input string s);
    line_bytes_t q;
    byte         ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      q.push_back(ch[6:0]);
    end
    return q;
  endfunction

  function automatic line_bytes_t rand_chars(input int n, input int lo, input int hi);
    line_bytes_t q;
    logic [6:0]  c;
    repeat (n) begin
      do c = 7'($urandom_range(lo, hi)); while (c == CH_STX || c == CH_LF || c == CH_CR);
      q.push_back(c);
    end
    return q;
  endfunction

  function automatic line_bytes_t field_body(input bit known);
    line_bytes_t q;
    int          idx;
    idx = $urandom_range(0, 4);
    q = known ? str_bytes(known_labels[idx]) : str_bytes(other_labels[$urandom_range(0, 14)]);
    q.push_back(CH_SPACE);
    if (known && idx == 4) begin
      if ($urandom_range(0, 3) != 0) q = {q, str_bytes(tariff_names[$urandom_range(0, 5)])};
      else q = {q, rand_chars($urandom_range(0, 6), 0, 127)};
    end else if (known || $urandom_range(0, 1) == 0) begin
      // mostly short values, now and then long enough to saturate
      q = {q, rand_chars(($urandom_range(0, 7) == 0) ? $urandom_range(10, 12)
                                                      : $urandom_range(1, 9), CH_ZERO, CH_NINE)};
      if ($urandom_range(0, 7) == 0) q = {q, rand_chars($urandom_range(1, 3), 0, 127)};
    end else begin
      q = {q, rand_chars($urandom_range(0, 10), 0, 127)};
    end
    return q;
  endfunction

  function automatic void add_frame(input line_bytes_t body, input bit good);
    logic [7:0] sum;
    logic [6:0] chk;
    sum = '0;
    foreach (body[i]) begin
      sum = sum + {1'b0, body[i]};
      push_byte(body[i]);
    end
    chk = {1'b0, sum[5:0]} + CSUM_BIAS;
    if (!good) chk = {1'b0, sum[5:0] ^ 6'($urandom_range(1, 63))} + CSUM_BIAS;
    push_byte(($urandom_range(0, 3) == 0) ? 7'h09 : CH_SPACE);
    push_byte(chk);
    push_byte(CH_CR);
  endfunction

  function automatic void add_text_line(input string s, input bit good);
    add_frame(str_bytes(s), good);
  endfunction

  function automatic void directed_lines();
    line_bytes_t q;
    add_text_line("HCHP 000000000", 1'b1);
    add_text_line("HCHC 4294967295", 1'b1);
    add_text_line("IINST 999999999999", 1'b1);
    add_text_line("PAPP 00750", 1'b1);
    add_text_line("PTEC HP..", 1'b1);
    add_text_line("PTEC HC", 1'b1);
    add_text_line("ADCO 012345678901", 1'b1);
    add_text_line("IINST1 005", 1'b1);
    add_text_line("HCHP 12A34", 1'b1);
    add_text_line("HCHP", 1'b1);
    add_text_line("PTECX HP..", 1'b1);
    add_text_line("HCHC 000123", 1'b0);
    // zero bytes inside and after the label
    q = '{7'h48, 7'h43, 7'h48, 7'h50, 7'h00, 7'h37, 7'h00};
    add_frame(q, 1'b1);
    // lines cut short by LF and by STX
    q = str_bytes("HCHP 12");
    foreach (q[i]) push_byte(q[i]);
    push_byte(CH_LF);
    add_text_line("PAPP 01230", 1'b1);
    q = str_bytes("IINST 00");
    foreach (q[i]) push_byte(q[i]);
    push_byte(CH_STX);
    add_text_line("HCHC 77", 1'b1);
    // short lines
    push_byte(CH_CR);
    push_byte(7'h41);
    push_byte(CH_CR);
    push_byte(7'h41);
    push_byte(7'h42);
    push_byte(CH_CR);
    // overrun of the line buffer
    repeat (130) push_byte(7'h41);
    push_byte(CH_CR);
    // enough bad lines to exceed the reset limit
    repeat (11) push_byte(CH_CR);
  endfunction

  function automatic void random_lines(input int budget);
    int          start;
    int          pick;
    int          n;
    line_bytes_t q;
    start = pushed_bytes;
    while (pushed_bytes - start < budget) begin
      if ($urandom_range(0, 9) == 0) push_byte(($urandom_range(0, 1) != 0) ? CH_STX : CH_LF);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_frame(field_body(1'b1), 1'b1);
      end else if (pick < 65) begin
        add_frame(field_body(1'b0), 1'b1);
      end else if (pick < 77) begin
        add_frame(field_body(1'($urandom_range(0, 1))), 1'b0);
      end else if (pick < 85) begin
        q = field_body(1'($urandom_range(0, 1)));
        n = $urandom_range(0, q.size());
        for (int i = 0; i < n; i++) push_byte(q[i]);
        push_byte(($urandom_range(0, 1) != 0) ? CH_STX : CH_LF);
      end else if (pick < 92) begin
        q = rand_chars($urandom_range(0, 2), 0, 127);
        foreach (q[i]) push_byte(q[i]);
        push_byte(CH_CR);
      end else if (pick < 99) begin
        repeat ($urandom_range(1, 6)) push_raw(8'($urandom_range(0, 255)));
      end else begin
        q = rand_chars(LINE_LIMIT + $urandom_range(0, 4), 0, 127);
        foreach (q[i]) push_byte(q[i]);
      end
    end
  endfunction

  task automatic write_error_limit(input logic [7:0] v);
    @(negedge clk);
    cfg.valid       <= 1'b1;
    cfg.error_limit <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // sender holds off until the parser has drained every line
  task automatic wait_quiet();
    @(posedge clk);
    while (meter_bytes.size() != 0 || rx.valid || expected_lines.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // byte driver and result ready, both with random idle bursts outside the last stretch
  always @(negedge clk) begin
    if (rst) begin
      rx.valid  <= 1'b0;
      res.ready <= 1'b0;
    end else begin
      if (!rx.valid || rx_took) begin
        if (tx_gap != 0) begin
          tx_gap--;
          rx.valid <= 1'b0;
        end else if (meter_bytes.size() == 0) begin
          rx.valid <= 1'b0;
        end else if (!last_stretch && $urandom_range(0, 15) == 0) begin
          tx_gap = $urandom_range(0, 9);
          rx.valid <= 1'b0;
        end else begin
          rx.valid   <= 1'b1;
          rx.rx_byte <= meter_bytes.pop_front();
        end
      end
      if (res_gap != 0) begin
        res_gap--;
        res.ready <= 1'b0;
      end else if (!last_stretch && $urandom_range(0, 15) == 0) begin
        res_gap = $urandom_range(0, 9);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // monitor: predicts on each byte transaction, checks each result transaction
  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      rx_took <= 1'b0;
    end else begin
      rx_took <= rx.valid && rx.ready;
      if (rx.valid && rx.ready) predict_line_byte(rx.rx_byte);
      if (cfg.valid && cfg.ready) limit_now = cfg.error_limit;
      if (res.valid && res.ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: result with none expected, label_code %0d field_value %0h",
                   $time, res.label_code, res.field_value);
          mismatch_count++;
        end else begin
          want = expected_lines.pop_front();
          check_field("label_code", 32'(want.code), 32'(res.label_code));
          check_field("field_value", want.value, res.field_value);
          check_field("checksum_ok", 32'(want.ok), 32'(res.checksum_ok));
          check_field("set_complete", 32'(want.done), 32'(res.set_complete));
          check_field("error_abort", 32'(want.abort), 32'(res.error_abort));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("meter_teleinfo_line_parser_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    rx.valid        = 1'b0;
    rx.rx_byte      = '0;
    res.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.error_limit = '0;
    clear_line();
    limit_now = ERROR_LIMIT_RESET;
    seen_mask = '0;
    bad_lines = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_lines();
    wait_quiet();

    write_error_limit(8'd0);
    random_lines(150);
    wait_quiet();

    // long run of bad lines drives the error count into saturation
    write_error_limit(8'd255);
    repeat (260) push_byte(CH_CR);
    random_lines(150);
    wait_quiet();

    write_error_limit(8'($urandom_range(1, 15)));
    random_lines(150);
    wait_quiet();

    write_error_limit(8'($urandom_range(0, 255)));
    random_lines(150);
    wait_quiet();

    last_stretch = 1'b1;
    write_error_limit(8'($urandom_range(2, 5)));
    random_lines(150);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("meter_teleinfo_line_parser_core_tb: done, clean");
    end else begin
      $display("meter_teleinfo_line_parser_core_tb: done, errors");
    end
    $finish;
  end

endmodule
